[design/essq_pkg.sv]
// Shared types and codes for the expiry-sorted stock queue.
package essq_pkg;

    localparam int QTY_W   = 16;
    localparam int EXP_W   = 16;
    localparam int TOTAL_W = 20;

    typedef enum logic [1:0] {
        MODE_ADD     = 2'd0,
        MODE_CONSUME = 2'd1,
        MODE_POP     = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_POP_EMPTY = 2'd1,
        STAT_DROPPED   = 2'd2,
        STAT_SHORTFALL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT,
        OP_SET_HEAD
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_CONSUME
    } state_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [QTY_W-1:0] qty;
        logic [EXP_W-1:0] expiry;
    } in_t;

    typedef struct packed {
        logic [QTY_W-1:0]   popped_qty;
        logic [EXP_W-1:0]   popped_expiry;
        logic [TOTAL_W-1:0] total_stock;
        logic [1:0]         status;
    } out_t;

    typedef struct packed {
        logic [QTY_W-1:0] qty;
        logic [EXP_W-1:0] expiry;
    } lot_t;

    typedef struct packed {
        cell_op_t         op;
        lot_t             new_lot;
        logic [QTY_W-1:0] head_qty;
    } cell_cmd_t;

endpackage

[design/expiry_sorted_stock_queue_top.sv]
// Top level of the expiry-sorted stock queue: control, cell row and result register.
// Holds up to DEPTH lots in a row of cells sorted by ascending expiry, cell 0 being the
// earliest. On an add or a pop every cell compares its expiry with the new lot in
// parallel and the row shifts by one place in the same cycle. A consume drains the head
// cell one lot per cycle while the row shifts behind it. One request is in work at a
// time; a new beat is taken as soon as the row is free and the result register is empty
// or being taken. Each request gives exactly one result beat carrying the new total.
module expiry_sorted_stock_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  essq_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output essq_pkg::out_t out_data
);

    localparam int CW = $clog2(DEPTH + 1);

    essq_pkg::state_t                   state_reg, state_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [essq_pkg::TOTAL_W-1:0]       sum_reg, sum_next;
    logic [essq_pkg::QTY_W-1:0]         left_reg, left_next;
    logic                               out_valid_reg, out_valid_next;
    essq_pkg::out_t                     out_reg, out_next;

    essq_pkg::cell_cmd_t                cmd;
    essq_pkg::cell_cmd_t                cell_cmd [DEPTH];
    essq_pkg::lot_t                     cell_lot [DEPTH];
    logic [DEPTH-1:0]                   cell_lt;
    logic [DEPTH-1:0]                   occ;
    essq_pkg::lot_t                     head;
    logic                               accept;

    assign head     = cell_lot[0];
    assign in_stall = (state_reg != essq_pkg::S_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            essq_pkg::lot_t left_lot;
            essq_pkg::lot_t right_lot;
            logic           prev_lt;

            assign occ[g] = (CW'(g) < count_reg);

            if (g == 0)
            begin : g_head
                assign prev_lt  = 1'b1;
                assign left_lot = cmd.new_lot;
                assign cell_cmd[g] = cmd;
            end
            else
            begin : g_body
                assign prev_lt  = cell_lt[g-1];
                assign left_lot = cell_lot[g-1];
                always_comb
                begin
                    cell_cmd[g] = cmd;
                    if (cmd.op == essq_pkg::OP_SET_HEAD)
                    begin
                        cell_cmd[g].op = essq_pkg::OP_HOLD;
                    end
                end
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign right_lot = cmd.new_lot;
            end
            else
            begin : g_inner
                assign right_lot = cell_lot[g+1];
            end

            essq_cell u_cell (
                .clk       (clk),
                .cmd       (cell_cmd[g]),
                .occ       (occ[g]),
                .prev_lt   (prev_lt),
                .left_lot  (left_lot),
                .right_lot (right_lot),
                .lot       (cell_lot[g]),
                .lt        (cell_lt[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        cmd.op         = essq_pkg::OP_HOLD;
        cmd.new_lot    = '{qty: in_data.qty, expiry: in_data.expiry};
        cmd.head_qty   = head.qty - left_reg;

        unique case (state_reg)
            essq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    out_next.popped_qty    = '0;
                    out_next.popped_expiry = '0;
                    out_next.status        = essq_pkg::STAT_OK;
                    unique case (essq_pkg::mode_t'(in_data.mode))
                        essq_pkg::MODE_ADD:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                out_next.status = essq_pkg::STAT_DROPPED;
                            end
                            else
                            begin
                                cmd.op     = essq_pkg::OP_INSERT;
                                count_next = count_reg + CW'(1);
                                sum_next   = sum_reg + essq_pkg::TOTAL_W'(in_data.qty);
                            end
                        end
                        essq_pkg::MODE_CONSUME:
                        begin
                            left_next  = in_data.qty;
                            state_next = essq_pkg::S_CONSUME;
                        end
                        essq_pkg::MODE_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_next.status = essq_pkg::STAT_POP_EMPTY;
                            end
                            else
                            begin
                                cmd.op                 = essq_pkg::OP_SHIFT;
                                out_next.popped_qty    = head.qty;
                                out_next.popped_expiry = head.expiry;
                                count_next             = count_reg - CW'(1);
                                sum_next = sum_reg - essq_pkg::TOTAL_W'(head.qty);
                            end
                        end
                        default:
                        begin
                            out_next.status = essq_pkg::STAT_OK;
                        end
                    endcase
                    out_next.total_stock = sum_next;
                    out_valid_next       = (state_next == essq_pkg::S_IDLE);
                end
            end
            essq_pkg::S_CONSUME:
            begin
                out_next.popped_qty    = '0;
                out_next.popped_expiry = '0;
                out_next.status        = essq_pkg::STAT_OK;
                priority if (left_reg == '0)
                begin
                    state_next = essq_pkg::S_IDLE;
                end
                else if (count_reg == '0)
                begin
                    sum_next        = '0;
                    out_next.status = essq_pkg::STAT_SHORTFALL;
                    state_next      = essq_pkg::S_IDLE;
                end
                else if (left_reg >= head.qty)
                begin
                    cmd.op     = essq_pkg::OP_SHIFT;
                    left_next  = left_reg - head.qty;
                    count_next = count_reg - CW'(1);
                    sum_next   = sum_reg - essq_pkg::TOTAL_W'(head.qty);
                end
                else
                begin
                    cmd.op     = essq_pkg::OP_SET_HEAD;
                    left_next  = '0;
                    sum_next   = sum_reg - essq_pkg::TOTAL_W'(left_reg);
                    state_next = essq_pkg::S_IDLE;
                end
                out_next.total_stock = sum_next;
                if (state_next == essq_pkg::S_IDLE)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = essq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= essq_pkg::S_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[design/essq_cell.sv]
// One queue slot: holds a lot and trades it with its neighbors.
module essq_cell (
    input  logic                clk,
    input  essq_pkg::cell_cmd_t cmd,
    input  logic                occ,
    input  logic                prev_lt,
    input  essq_pkg::lot_t      left_lot,
    input  essq_pkg::lot_t      right_lot,
    output essq_pkg::lot_t      lot,
    output logic                lt
);

    essq_pkg::lot_t lot_reg;
    essq_pkg::lot_t lot_next;

    always_comb
    begin
        lt = occ && (lot_reg.expiry < cmd.new_lot.expiry);
    end

    always_comb
    begin
        lot_next = lot_reg;
        unique case (cmd.op)
            essq_pkg::OP_HOLD:
            begin
                lot_next = lot_reg;
            end
            essq_pkg::OP_INSERT:
            begin
                priority if (lt)
                begin
                    lot_next = lot_reg;
                end
                else if (prev_lt)
                begin
                    lot_next = cmd.new_lot;
                end
                else
                begin
                    lot_next = left_lot;
                end
            end
            essq_pkg::OP_SHIFT:
            begin
                lot_next = right_lot;
            end
            essq_pkg::OP_SET_HEAD:
            begin
                lot_next.qty = cmd.head_qty;
            end
            default:
            begin
                lot_next = lot_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        lot_reg <= lot_next;
    end

    assign lot = lot_reg;

endmodule

[design/essq_checker.sv]
// Port-level checks for the expiry-sorted stock queue and their binding.
module essq_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input essq_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_stall,
    input essq_pkg::out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("stalled result beat changed");

    a_pop_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.mode == essq_pkg::MODE_POP) |=> out_valid)
        else $error("pop result not ready in the next cycle");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == essq_pkg::STAT_POP_EMPTY)
        |-> (out_data.popped_qty == '0) && (out_data.popped_expiry == '0))
        else $error("pop on empty returned a lot");

    a_shortfall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == essq_pkg::STAT_SHORTFALL)
        |-> (out_data.total_stock == '0))
        else $error("shortfall left stock behind");

endmodule

bind expiry_sorted_stock_queue_top essq_checker u_essq_checker (.*);

[dv/essq_stock_check.sv]
// Checker for the expiry-sorted stock queue: tracks requests, predicts and compares results.
module essq_stock_check #(
    parameter int DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  essq_pkg::in_t  in_data,
    input  logic           out_valid,
    input  logic           out_stall,
    input  essq_pkg::out_t out_data,
    output int             errors,
    output int             pending,
    output int             results,
    output int             drops,
    output int             shortfalls
);
    timeunit 1ns;
    timeprecision 1ps;

    essq_pkg::lot_t               shelf [DEPTH];
    int                           lots;
    logic [essq_pkg::TOTAL_W-1:0] stock;
    essq_pkg::out_t               awaited_results [$];
    essq_pkg::out_t               want;
    int                           fails;
    int                           seen;
    int                           dropped;
    int                           short_count;

    function automatic void drop_front();
        for (int i = 1; i < lots; i++)
        begin
            shelf[i-1] = shelf[i];
        end
        lots--;
    endfunction

    function automatic essq_pkg::out_t apply_request(essq_pkg::in_t req);
        essq_pkg::out_t             r;
        int                         pos;
        logic [essq_pkg::QTY_W-1:0] left;
        r = '0;
        unique case (req.mode)
            essq_pkg::MODE_ADD:
            begin
                if (lots >= DEPTH)
                begin
                    r.status = essq_pkg::STAT_DROPPED;
                end
                else
                begin
                    pos = 0;
                    while (pos < lots && shelf[pos].expiry < req.expiry)
                    begin
                        pos++;
                    end
                    for (int i = lots; i > pos; i--)
                    begin
                        shelf[i] = shelf[i-1];
                    end
                    shelf[pos].qty    = req.qty;
                    shelf[pos].expiry = req.expiry;
                    lots++;
                    stock = stock + essq_pkg::TOTAL_W'(req.qty);
                end
            end
            essq_pkg::MODE_CONSUME:
            begin
                left = req.qty;
                while (left != '0 && lots != 0)
                begin
                    if (left >= shelf[0].qty)
                    begin
                        left  = left - shelf[0].qty;
                        stock = stock - essq_pkg::TOTAL_W'(shelf[0].qty);
                        drop_front();
                    end
                    else
                    begin
                        shelf[0].qty = shelf[0].qty - left;
                        stock        = stock - essq_pkg::TOTAL_W'(left);
                        left         = '0;
                    end
                end
                if (left != '0)
                begin
                    lots     = 0;
                    stock    = '0;
                    r.status = essq_pkg::STAT_SHORTFALL;
                end
            end
            essq_pkg::MODE_POP:
            begin
                if (lots == 0)
                begin
                    r.status = essq_pkg::STAT_POP_EMPTY;
                end
                else
                begin
                    r.popped_qty    = shelf[0].qty;
                    r.popped_expiry = shelf[0].expiry;
                    stock           = stock - essq_pkg::TOTAL_W'(shelf[0].qty);
                    drop_front();
                end
            end
            default:
            begin
            end
        endcase
        r.total_stock = stock;
        return r;
    endfunction

    task automatic check_field(string name, logic [essq_pkg::TOTAL_W-1:0] exp_v,
                               logic [essq_pkg::TOTAL_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lots        = 0;
            stock       = '0;
            fails       = 0;
            seen        = 0;
            dropped     = 0;
            short_count = 0;
            awaited_results.delete();
            errors     <= 0;
            pending    <= 0;
            results    <= 0;
            drops      <= 0;
            shortfalls <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen++;
                if (awaited_results.size() == 0)
                begin
                    $error("result beat with no request waiting: %h", out_data);
                    fails++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("popped_qty", essq_pkg::TOTAL_W'(want.popped_qty),
                                essq_pkg::TOTAL_W'(out_data.popped_qty));
                    check_field("popped_expiry", essq_pkg::TOTAL_W'(want.popped_expiry),
                                essq_pkg::TOTAL_W'(out_data.popped_expiry));
                    check_field("total_stock", want.total_stock, out_data.total_stock);
                    check_field("status", essq_pkg::TOTAL_W'(want.status),
                                essq_pkg::TOTAL_W'(out_data.status));
                    if (want.status == essq_pkg::STAT_DROPPED)
                    begin
                        dropped++;
                    end
                    if (want.status == essq_pkg::STAT_SHORTFALL)
                    begin
                        short_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                awaited_results.push_back(apply_request(in_data));
            end
            errors     <= fails;
            pending    <= awaited_results.size();
            results    <= seen;
            drops      <= dropped;
            shortfalls <= short_count;
        end
    end

endmodule

[dv/testbench.sv]
// Testbench top for the expiry-sorted stock queue: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         DEPTH       = 16;
    localparam int         PHASES      = 10;
    localparam int         PHASE_ITEMS = 50;
    localparam int         CYCLE_LIMIT = 200000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    essq_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_stall;
    essq_pkg::out_t out_data;

    int errors;
    int pending;
    int results;
    int drops;
    int shortfalls;
    int requests_sent = 0;
    int cycle_count   = 0;
    bit tx_quiet      = 1'b0;
    bit rx_quiet      = 1'b0;

    expiry_sorted_stock_queue_top #(
        .DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    essq_stock_check #(
        .DEPTH(DEPTH)
    ) stock_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending),
        .results   (results),
        .drops     (drops),
        .shortfalls(shortfalls)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic offer_request(input logic [1:0] op, input logic [15:0] amount,
                                 input logic [15:0] date);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{mode: op, qty: amount, expiry: date};
        do @(posedge clk); while (in_stall);
        requests_sent++;
    endtask

    function automatic logic [15:0] draw_amount();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
        begin
            return '0;
        end
        else if (roll <= 2)
        begin
            return 16'($urandom_range(0, 65535));
        end
        return 16'($urandom_range(1, 999));
    endfunction

    // hold stall for a random count per result beat, then wait for the beat
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = rx_quiet ? 0 : $urandom_range(0, 18);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    initial
    begin
        mix_t        mix;
        bit          narrow;
        int          roll;
        logic [15:0] date;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_request(essq_pkg::MODE_POP, 16'd0, 16'd0);
        offer_request(essq_pkg::MODE_CONSUME, 16'd0, 16'd0);
        offer_request(essq_pkg::MODE_CONSUME, 16'd5, 16'd0);
        offer_request(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
        offer_request(essq_pkg::MODE_ADD, 16'd0, 16'd100);
        offer_request(essq_pkg::MODE_ADD, 16'hFFFF, 16'd0);
        offer_request(essq_pkg::MODE_ADD, 16'd10, 16'hFFFF);
        offer_request(essq_pkg::MODE_ADD, 16'd20, 16'd100);
        offer_request(MODE_UNUSED, 16'd3, 16'd3);
        offer_request(essq_pkg::MODE_CONSUME, 16'd0, 16'd0);
        offer_request(essq_pkg::MODE_CONSUME, 16'hFFFF, 16'd0);
        offer_request(essq_pkg::MODE_CONSUME, 16'd25, 16'd0);
        offer_request(essq_pkg::MODE_CONSUME, 16'd5, 16'd0);
        offer_request(essq_pkg::MODE_POP, 16'd0, 16'd0);
        offer_request(essq_pkg::MODE_ADD, 16'd7, 16'd9);
        offer_request(essq_pkg::MODE_ADD, 16'd8, 16'd4);
        offer_request(essq_pkg::MODE_POP, 16'hFFFF, 16'hFFFF);
        offer_request(essq_pkg::MODE_CONSUME, 16'hFFFF, 16'hFFFF);
        offer_request(essq_pkg::MODE_POP, 16'd0, 16'd0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            mix      = mix_t'(phase % 3);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            narrow   = 1'($urandom_range(0, 1));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                date = narrow ? 16'($urandom_range(0, 7)) : 16'($urandom_range(0, 65535));
                unique case (mix)
                    MIX_FILL:  roll = (roll < 80) ? 0 : (roll < 88) ? 1 : (roll < 98) ? 2 : 3;
                    MIX_DRAIN: roll = (roll < 30) ? 0 : (roll < 65) ? 1 : (roll < 97) ? 2 : 3;
                    default:   roll = (roll < 50) ? 0 : (roll < 75) ? 1 : (roll < 97) ? 2 : 3;
                endcase
                unique case (roll)
                    0:       offer_request(essq_pkg::MODE_ADD, draw_amount(), date);
                    1:       offer_request(essq_pkg::MODE_CONSUME, draw_amount(), date);
                    2:       offer_request(essq_pkg::MODE_POP, draw_amount(), date);
                    default: offer_request(MODE_UNUSED, draw_amount(), date);
                endcase
            end
        end
        in_valid <= 1'b0;
        rx_quiet = 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DEPTH + 4) @(posedge clk);

        $display("%0d requests sent, %0d result beats checked", requests_sent, results);
        $display("adds dropped on a full queue: %0d, consume shortfalls: %0d", drops, shortfalls);
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
design/essq_pkg.sv
design/essq_cell.sv
design/expiry_sorted_stock_queue_top.sv
design/essq_checker.sv
dv/essq_stock_check.sv
dv/testbench.sv
